// ===== rtl/orsb_pkg.sv =====
package orsb_pkg;

    localparam int unsigned COMMAND_W = 2;
    localparam int unsigned SAMPLE_W  = 16;
    localparam int unsigned COUNT_W   = 7;
    // cell positions: one code per cell of a chain up to 64 deep
    localparam int unsigned POS_W     = 6;

    localparam logic [COMMAND_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [COMMAND_W-1:0] CMD_DUMP   = 2'd1;
    localparam logic [COMMAND_W-1:0] CMD_RESIZE = 2'd2;

    typedef struct packed {
        logic             shift;      // every cell takes its upper neighbor
        logic             wrap;       // cell at last_pos takes the head instead
        logic             write_en;   // cell at write_pos takes the new sample
        logic [POS_W-1:0] write_pos;
        logic [POS_W-1:0] last_pos;
    } cell_ctrl_t;

endpackage

// ===== rtl/orsb_cell.sv =====
module orsb_cell #(
    parameter int unsigned INDEX = 0,
    parameter int unsigned WIDTH = 16
) (
    input  logic                  clk,
    input  orsb_pkg::cell_ctrl_t  ctl,
    input  logic [WIDTH-1:0]      neighbor,
    input  logic [WIDTH-1:0]      head,
    input  logic [WIDTH-1:0]      sample,
    output logic [WIDTH-1:0]      data
);
    import orsb_pkg::*;

    localparam logic [POS_W-1:0] MY_POS = POS_W'(INDEX);

    logic [WIDTH-1:0] data_reg;
    logic [WIDTH-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctl.shift)
        begin
            if (ctl.wrap && (ctl.last_pos == MY_POS))
                data_next = head;
            else
                data_next = neighbor;
        end
        if (ctl.write_en && (ctl.write_pos == MY_POS))
            data_next = sample;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ===== rtl/orsb_ctrl.sv =====
module orsb_ctrl #(
    parameter int unsigned DEPTH       = 64,
    parameter int unsigned SAMPLE_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cmd_valid,
    output logic                                cmd_stall,
    input  logic [orsb_pkg::COMMAND_W-1:0]      command,
    input  logic [orsb_pkg::COUNT_W-1:0]        new_capacity,
    input  logic [SAMPLE_BITS-1:0]              head,
    output orsb_pkg::cell_ctrl_t                ctl,
    output logic                                res_valid,
    input  logic                                res_stall,
    output logic [orsb_pkg::SAMPLE_W-1:0]       sample_out,
    output logic                                is_last,
    output logic                                is_empty,
    output logic [orsb_pkg::COUNT_W-1:0]        stored_count
);
    import orsb_pkg::*;

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0]   DEPTH_CNT = CNT_W'(DEPTH);
    localparam logic [COUNT_W-1:0] DEPTH_REQ = COUNT_W'(DEPTH);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DUMP = 2'd1;
    localparam logic [1:0] ST_TRIM = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] cap_reg, cap_next;
    logic [CNT_W-1:0] idx_reg, idx_next;

    logic                 res_valid_reg, res_valid_next;
    logic [SAMPLE_W-1:0]  sample_reg;
    logic                 last_reg;
    logic                 empty_reg;
    logic [COUNT_W-1:0]   count_reg;

    logic                 accept;
    logic                 out_free;
    logic                 load;
    logic [SAMPLE_W-1:0]  load_sample;
    logic                 load_last;
    logic                 load_empty;
    logic [COUNT_W-1:0]   cap_sat;
    logic [SAMPLE_BITS+SAMPLE_W-1:0] head_wide;

    assign cmd_stall = (state_reg != ST_IDLE);
    assign accept    = cmd_valid && !cmd_stall;
    assign out_free  = !res_valid_reg || !res_stall;
    assign cap_sat   = (new_capacity > DEPTH_REQ) ? DEPTH_REQ : new_capacity;
    assign head_wide = {{SAMPLE_W{1'b0}}, head};

    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        cap_next    = cap_reg;
        idx_next    = idx_reg;
        ctl         = '0;
        load        = 1'b0;
        load_sample = '0;
        load_last   = 1'b0;
        load_empty  = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (command)
                        CMD_INSERT:
                        begin
                            // zero capacity discards the sample
                            if (cap_reg != '0)
                            begin
                                ctl.write_en = 1'b1;
                                if (fill_reg == cap_reg)
                                begin
                                    // full: drop the oldest by shifting down
                                    ctl.shift     = 1'b1;
                                    ctl.write_pos = POS_W'(cap_reg - 1'b1);
                                end
                                else
                                begin
                                    ctl.write_pos = POS_W'(fill_reg);
                                    fill_next     = fill_reg + 1'b1;
                                end
                            end
                        end
                        CMD_DUMP:
                        begin
                            idx_next   = '0;
                            state_next = ST_DUMP;
                        end
                        CMD_RESIZE:
                        begin
                            cap_next   = cap_sat[CNT_W-1:0];
                            state_next = ST_TRIM;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_DUMP:
            begin
                if (out_free)
                begin
                    load = 1'b1;
                    if (fill_reg == '0)
                    begin
                        load_last  = 1'b1;
                        load_empty = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        // emit the head and rotate it to the back of the held run
                        load_sample   = head_wide[SAMPLE_W-1:0];
                        load_last     = (idx_reg == fill_reg - 1'b1);
                        ctl.shift     = 1'b1;
                        ctl.wrap      = 1'b1;
                        ctl.last_pos  = POS_W'(fill_reg - 1'b1);
                        idx_next      = idx_reg + 1'b1;
                        if (load_last)
                            state_next = ST_IDLE;
                    end
                end
            end
            ST_TRIM:
            begin
                if (fill_reg > cap_reg)
                begin
                    ctl.shift = 1'b1;
                    fill_next = fill_reg - 1'b1;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (load)
            res_valid_next = 1'b1;
        else if (res_stall)
            res_valid_next = res_valid_reg;
        else
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            cap_reg       <= DEPTH_CNT;
            idx_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            cap_reg       <= cap_next;
            idx_reg       <= idx_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sample_reg <= load_sample;
            last_reg   <= load_last;
            empty_reg  <= load_empty;
            count_reg  <= COUNT_W'(fill_reg);
        end
    end

    assign res_valid    = res_valid_reg;
    assign sample_out   = sample_reg;
    assign is_last      = last_reg;
    assign is_empty     = empty_reg;
    assign stored_count = count_reg;

endmodule

// ===== rtl/overwrite_ring_sample_buffer_core.sv =====
// channel   valid       stall       payload
// cmd       cmd_valid   cmd_stall   command, sample_in, new_capacity
// res       res_valid   res_stall   sample_out, is_last, is_empty, stored_count
//
// Samples sit in a chain of cells, oldest in cell 0. A dump emits one word per
// held sample (one for an empty ring): the chain rotates one place per word past
// the single head tap. Resize shifts the dropped samples out, one a cycle.
// Reset clears count and sets capacity to DEPTH; cell contents are not reset.
// A stall on res holds the current word and pauses the rotation.
module overwrite_ring_sample_buffer_core #(
    parameter int unsigned DEPTH       = 64,
    parameter int unsigned SAMPLE_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cmd_valid,
    output logic                            cmd_stall,
    input  logic [orsb_pkg::COMMAND_W-1:0]  command,
    input  logic [orsb_pkg::SAMPLE_W-1:0]   sample_in,
    input  logic [orsb_pkg::COUNT_W-1:0]    new_capacity,
    output logic                            res_valid,
    input  logic                            res_stall,
    output logic [orsb_pkg::SAMPLE_W-1:0]   sample_out,
    output logic                            is_last,
    output logic                            is_empty,
    output logic [orsb_pkg::COUNT_W-1:0]    stored_count
);
    import orsb_pkg::*;

    cell_ctrl_t                       ctl;
    logic [SAMPLE_BITS-1:0]           cell_data [DEPTH];
    logic [SAMPLE_BITS+SAMPLE_W-1:0]  sample_wide;

    // mask or extend the incoming sample to the cell width
    assign sample_wide = {{SAMPLE_BITS{1'b0}}, sample_in};

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [SAMPLE_BITS-1:0] upper;
        if (i == DEPTH - 1)
        begin : g_top
            assign upper = cell_data[i];
        end
        else
        begin : g_mid
            assign upper = cell_data[i+1];
        end

        orsb_cell #(
            .INDEX (i),
            .WIDTH (SAMPLE_BITS)
        ) u_cell (
            .clk      (clk),
            .ctl      (ctl),
            .neighbor (upper),
            .head     (cell_data[0]),
            .sample   (sample_wide[SAMPLE_BITS-1:0]),
            .data     (cell_data[i])
        );
    end

    orsb_ctrl #(
        .DEPTH       (DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall),
        .command      (command),
        .new_capacity (new_capacity),
        .head         (cell_data[0]),
        .ctl          (ctl),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .sample_out   (sample_out),
        .is_last      (is_last),
        .is_empty     (is_empty),
        .stored_count (stored_count)
    );

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import orsb_pkg::*;

    localparam int unsigned DEPTH        = 64;
    localparam int unsigned SAMPLE_BITS  = 16;
    localparam logic [COMMAND_W-1:0] CMD_UNUSED = 2'd3;
    localparam int unsigned CLK_HALF     = 4;
    localparam int unsigned RESET_CYCLES = 5;
    localparam int unsigned PHASE_WORDS  = 32;
    // a resize may shift out every held sample after its last word
    localparam int unsigned DRAIN_CYCLES = 2 * DEPTH + 16;
    localparam int unsigned CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                last;
        logic                empty;
        logic [COUNT_W-1:0]  count;
    } dump_word_t;

    class ring_scoreboard;
        logic [SAMPLE_W-1:0] held [DEPTH];
        int unsigned oldest_pos;
        int unsigned write_pos;
        int unsigned fill;
        int unsigned capacity;
        dump_word_t  due_q [$];
        int unsigned n_insert;
        int unsigned n_dump;
        int unsigned n_empty_dump;
        int unsigned n_resize;
        int unsigned n_saturated;
        int unsigned n_checked;

        function new();
            foreach (held[i]) held[i] = '0;
            oldest_pos   = 0;
            write_pos    = 0;
            fill         = 0;
            capacity     = DEPTH;
            n_insert     = 0;
            n_dump       = 0;
            n_empty_dump = 0;
            n_resize     = 0;
            n_saturated  = 0;
            n_checked    = 0;
        endfunction

        // returns 1 for a dump, a resize, or an insert into a nonzero capacity
        function bit note_command(input logic [COMMAND_W-1:0] cmd,
                                  input logic [SAMPLE_W-1:0] smp,
                                  input logic [COUNT_W-1:0] req);
            dump_word_t  w;
            int unsigned cap;
            case (cmd)
                CMD_INSERT:
                begin
                    if (capacity == 0)
                        return 1'b0;
                    held[write_pos] = SAMPLE_W'(smp & ((1 << SAMPLE_BITS) - 1));
                    write_pos = (write_pos + 1) % DEPTH;
                    if (fill < capacity)
                        fill++;
                    else
                        oldest_pos = (oldest_pos + 1) % DEPTH;
                    n_insert++;
                    return 1'b1;
                end
                CMD_RESIZE:
                begin
                    cap = req;
                    if (cap > DEPTH)
                    begin
                        cap = DEPTH;
                        n_saturated++;
                    end
                    capacity = cap;
                    // drop the oldest samples that no longer fit
                    if (fill > cap)
                    begin
                        oldest_pos = (oldest_pos + fill - cap) % DEPTH;
                        fill = cap;
                    end
                    n_resize++;
                    return 1'b1;
                end
                CMD_DUMP:
                begin
                    n_dump++;
                    if (fill == 0)
                    begin
                        w.sample = '0;
                        w.last   = 1'b1;
                        w.empty  = 1'b1;
                        w.count  = '0;
                        due_q.push_back(w);
                        n_empty_dump++;
                        return 1'b1;
                    end
                    for (int unsigned k = 0; k < fill; k++)
                    begin
                        w.sample = held[(oldest_pos + k) % DEPTH];
                        w.last   = (k + 1 == fill);
                        w.empty  = 1'b0;
                        w.count  = fill[COUNT_W-1:0];
                        due_q.push_back(w);
                    end
                    return 1'b1;
                end
                default: return 1'b0;
            endcase
        endfunction

        // returns an empty string when the word matches the oldest expectation
        function string check_word(input logic [SAMPLE_W-1:0] smp, input logic last,
                                   input logic empty, input logic [COUNT_W-1:0] count);
            dump_word_t w;
            string      msg;
            n_checked++;
            if (due_q.size() == 0)
                return $sformatf("unexpected word sample=%h last=%b empty=%b count=%0d",
                                 smp, last, empty, count);
            w   = due_q.pop_front();
            msg = "";
            if (smp !== w.sample)
                msg = {msg, $sformatf(" sample_out %h/%h", smp, w.sample)};
            if (last !== w.last)
                msg = {msg, $sformatf(" is_last %b/%b", last, w.last)};
            if (empty !== w.empty)
                msg = {msg, $sformatf(" is_empty %b/%b", empty, w.empty)};
            if (count !== w.count)
                msg = {msg, $sformatf(" stored_count %0d/%0d", count, w.count)};
            if (msg != "")
                msg = {$sformatf("word %0d mismatch (got/exp):", n_checked), msg};
            return msg;
        endfunction

        function int unsigned pending();
            return due_q.size();
        endfunction
    endclass

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  cmd_valid    = 1'b0;
    logic                  cmd_stall;
    logic [COMMAND_W-1:0]  command      = CMD_UNUSED;
    logic [SAMPLE_W-1:0]   sample_in    = '0;
    logic [COUNT_W-1:0]    new_capacity = '0;
    logic                  res_valid;
    logic                  res_stall    = 1'b0;
    logic [SAMPLE_W-1:0]   sample_out;
    logic                  is_last;
    logic                  is_empty;
    logic [COUNT_W-1:0]    stored_count;

    ring_scoreboard ring         = new();
    int unsigned    error_count  = 0;
    int unsigned    applied_count = 0;
    int unsigned    sender_idle_pct = 0;
    int unsigned    stall_pct    = 0;

    overwrite_ring_sample_buffer_core #(
        .DEPTH       (DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall),
        .command      (command),
        .sample_in    (sample_in),
        .new_capacity (new_capacity),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .sample_out   (sample_out),
        .is_last      (is_last),
        .is_empty     (is_empty),
        .stored_count (stored_count)
    );

    initial
    begin
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    task automatic send_word(input logic [COMMAND_W-1:0] cmd,
                             input logic [SAMPLE_W-1:0] smp,
                             input logic [COUNT_W-1:0] req);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid    <= 1'b1;
        command      <= cmd;
        sample_in    <= smp;
        new_capacity <= req;
        @(posedge clk);
        // hold the word until the block takes it
        while (cmd_stall)
            @(posedge clk);
        if (ring.note_command(cmd, smp, req))
            applied_count++;
    endtask

    task automatic send_random_word();
        int unsigned          pick;
        int unsigned          burst;
        logic [COUNT_W-1:0]   req;
        pick = $urandom_range(99);
        if (pick < 55)
        begin
            burst = $urandom_range(20, 1);
            repeat (burst)
                send_word(CMD_INSERT, SAMPLE_W'($urandom_range(16'hFFFF)),
                          COUNT_W'($urandom_range(127)));
        end
        else if (pick < 75)
            send_word(CMD_DUMP, SAMPLE_W'($urandom_range(16'hFFFF)),
                      COUNT_W'($urandom_range(127)));
        else if (pick < 93)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
                req = '0;
            else if (pick < 22)
                req = COUNT_W'($urandom_range(127, DEPTH + 1));
            else if (pick < 45)
                req = COUNT_W'(DEPTH);
            else
                req = COUNT_W'($urandom_range(DEPTH - 1, 1));
            send_word(CMD_RESIZE, SAMPLE_W'($urandom_range(16'hFFFF)), req);
        end
        else
            send_word(CMD_UNUSED, SAMPLE_W'($urandom_range(16'hFFFF)),
                      COUNT_W'($urandom_range(127)));
    endtask

    // result side: check every accepted word, stall at random
    initial
    begin
        string msg;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_valid && !res_stall)
            begin
                msg = ring.check_word(sample_out, is_last, is_empty, stored_count);
                if (msg != "")
                    report_mismatch(msg);
            end
            res_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    initial
    begin
        int unsigned watchdog;
        watchdog = 0;
        while (watchdog < CYCLE_LIMIT)
        begin
            @(posedge clk);
            watchdog++;
        end
        $display("timeout after %0d cycles, %0d words still due", watchdog, ring.pending());
        $display("** overwrite_ring_sample_buffer_core: FAILED **");
        $finish;
    end

    initial
    begin
        int unsigned goal;
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty ring, extremes, every command, saturation, zero and shrink
        send_word(CMD_DUMP,   16'h0000, 7'd0);
        send_word(CMD_INSERT, 16'h0000, 7'd127);
        send_word(CMD_INSERT, 16'hFFFF, 7'd0);
        send_word(CMD_INSERT, 16'hA5A5, 7'd64);
        send_word(CMD_DUMP,   16'hFFFF, 7'd127);
        send_word(CMD_UNUSED, 16'hFFFF, 7'd127);
        send_word(CMD_DUMP,   16'h0000, 7'd0);
        send_word(CMD_RESIZE, 16'h0000, 7'd127);
        send_word(CMD_RESIZE, 16'hFFFF, 7'd2);
        send_word(CMD_INSERT, 16'h5A5A, 7'd0);
        send_word(CMD_DUMP,   16'h0000, 7'd0);
        send_word(CMD_RESIZE, 16'h0000, 7'd0);
        send_word(CMD_INSERT, 16'h1234, 7'd0);
        send_word(CMD_DUMP,   16'h0000, 7'd0);
        send_word(CMD_RESIZE, 16'h0000, 7'd65);
        send_word(CMD_RESIZE, 16'h0000, 7'd1);
        send_word(CMD_INSERT, 16'h8001, 7'd0);
        send_word(CMD_INSERT, 16'h7FFE, 7'd0);
        send_word(CMD_DUMP,   16'h0000, 7'd0);
        send_word(CMD_RESIZE, 16'h0000, 7'd64);
        send_word(CMD_DUMP,   16'h0000, 7'd0);

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    sender_idle_pct = 0;
                    stall_pct       = 0;
                end
                1:
                begin
                    sender_idle_pct = 47;
                    stall_pct       = 0;
                end
                2:
                begin
                    sender_idle_pct = 0;
                    stall_pct       = 47;
                end
                default:
                begin
                    sender_idle_pct = 8;
                    stall_pct       = 8;
                end
            endcase
            goal = applied_count + PHASE_WORDS;
            while (applied_count < goal)
                send_random_word();
        end

        // drop valid right after the last word is taken
        cmd_valid <= 1'b0;
        while (ring.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (ring.pending() != 0)
            report_mismatch($sformatf("%0d expected words never arrived", ring.pending()));

        $display("covered %0d inserts, %0d resizes (%0d saturated), %0d dumps (%0d empty)",
                 ring.n_insert, ring.n_resize, ring.n_saturated, ring.n_dump,
                 ring.n_empty_dump);
        $display("checked %0d result words, %0d mismatches", ring.n_checked, error_count);
        if (error_count == 0)
            $display("** overwrite_ring_sample_buffer_core: PASSED **");
        else
            $display("** overwrite_ring_sample_buffer_core: FAILED **");
        $finish;
    end

endmodule
